>>> design/vp9rtp_pkg.sv
// ----------------------------------------------------------------------------
// vp9rtp_pkg
// Shared types, flag positions and helpers for the VP9 RTP descriptor parser.
// ----------------------------------------------------------------------------
package vp9rtp_pkg;

	// Where the parser stands inside the payload descriptor.
	typedef enum logic [3:0] {
		PH_FLAGS   = 4'd0,
		PH_PID1    = 4'd1,
		PH_PID2    = 4'd2,
		PH_LAYER   = 4'd3,
		PH_TL0     = 4'd4,
		PH_REF     = 4'd5,
		PH_SS      = 4'd6,
		PH_SIZES   = 4'd7,
		PH_NG      = 4'd8,
		PH_GROUP   = 4'd9,
		PH_DIFFS   = 4'd10,
		PH_PAYLOAD = 4'd11
	} phase_t;

	// Descriptor sections, in the order in which they may appear.
	typedef enum logic [1:0] {
		SEC_PID   = 2'd0,
		SEC_LAYER = 2'd1,
		SEC_REF   = 2'd2,
		SEC_SS    = 2'd3
	} section_t;

	// Stored flags are the flags byte shifted right by one.
	typedef logic [6:0] flags_t;

	localparam int unsigned FL_I = 6;
	localparam int unsigned FL_P = 5;
	localparam int unsigned FL_L = 4;
	localparam int unsigned FL_F = 3;
	localparam int unsigned FL_B = 2;
	localparam int unsigned FL_V = 0;

	// Most reference-diff bytes that one descriptor may chain.
	localparam logic [1:0] MAX_REFS = 2'd3;

	// First section at or after sec that the flags say is present.
	function automatic phase_t phase_from(input section_t sec, input flags_t f);
		phase_t ph;
		if (sec == SEC_PID && f[FL_I]) begin
			ph = PH_PID1;
		end else if ((sec == SEC_PID || sec == SEC_LAYER) && f[FL_L]) begin
			ph = PH_LAYER;
		end else if (sec != SEC_SS && f[FL_P] && f[FL_F]) begin
			ph = PH_REF;
		end else if (f[FL_V]) begin
			ph = PH_SS;
		end else begin
			ph = PH_PAYLOAD;
		end
		return ph;
	endfunction

endpackage

>>> design/vp9_rtp_descriptor_parser.sv
// ----------------------------------------------------------------------------
// vp9_rtp_descriptor_parser
// Strips the VP9 RTP payload descriptor from a byte stream and tags the
// remaining bytes as payload, with frame begin, frame end and error marks.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Fields
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | data_byte, first_byte, last_byte, marker_bit
//  out     | out_valid/out_ready | out_byte, is_payload, frame_begin,
//          |                     | frame_end, packet_error, end_of_packet
//
// Each accepted request yields exactly one registered result. A new request can
// be taken in every cycle unless a held result stalls it: the parse state and
// result register are written at the accepting edge, so throughput is one byte
// per clock. arst_n clears the parse state and the result valid flag; the first
// byte after reset is taken as a flags byte. While a result is held with
// out_ready low, in_ready drops and the input side waits; no result is ever lost.
//
module vp9_rtp_descriptor_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       marker_bit,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_payload,
	output logic       frame_begin,
	output logic       frame_end,
	output logic       packet_error,
	output logic       end_of_packet
);
	import vp9rtp_pkg::*;

	// Parse state, carried from byte to byte within a packet.
	phase_t       phase_q,  phase_d;
	flags_t       flags_q,  flags_d;
	logic [5:0]   skip_q,   skip_d;
	logic [7:0]   groups_q, groups_d;
	logic [1:0]   diffs_q,  diffs_d;
	logic [1:0]   refs_q,   refs_d;
	logic         seen_q,   seen_d;

	// Result register.
	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic         pay_q, fb_q, fe_q, err_q, eop_q;

	// Working values for the byte being accepted.
	phase_t       cur_phase;
	phase_t       step_phase;
	logic [1:0]   refs_inc;
	logic [5:0]   skip_dec;
	logic [7:0]   groups_dec;
	logic [1:0]   diffs_dec;
	logic [1:0]   diffs_new;
	logic         pay;
	logic         fb;
	logic         accept;

	// The result register frees up when it is empty or is being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// A start mark forces the byte to be read as a flags byte.
	assign cur_phase  = first_byte ? PH_FLAGS : phase_q;
	assign refs_inc   = refs_q + 2'd1;
	assign skip_dec   = skip_q - 6'd1;
	assign groups_dec = groups_q - 8'd1;
	assign diffs_dec  = diffs_q - 2'd1;
	assign diffs_new  = data_byte[3:2];

	// Next parse state for this byte, before the end-of-packet reset.
	always_comb begin
		step_phase = cur_phase;
		flags_d    = flags_q;
		skip_d     = skip_q;
		groups_d   = groups_q;
		diffs_d    = diffs_q;
		refs_d     = refs_q;
		seen_d     = seen_q;
		case (cur_phase)
			PH_PID1: begin
				step_phase = data_byte[7] ? PH_PID2 : phase_from(SEC_LAYER, flags_q);
			end
			PH_PID2: begin
				step_phase = phase_from(SEC_LAYER, flags_q);
			end
			PH_LAYER: begin
				step_phase = flags_q[FL_F] ? phase_from(SEC_REF, flags_q) : PH_TL0;
			end
			PH_TL0: begin
				step_phase = phase_from(SEC_REF, flags_q);
			end
			PH_REF: begin
				refs_d = refs_inc;
				// The chain ends on a clear N bit or after the third diff.
				if (!(data_byte[0] && refs_inc < MAX_REFS)) begin
					step_phase = phase_from(SEC_SS, flags_q);
				end
			end
			PH_SS: begin
				if (data_byte[4]) begin
					skip_d     = {1'b0, data_byte[7:5] + 3'd1, 2'b00} + {data_byte[7:5] == 3'd7, 5'd0};
					step_phase = PH_SIZES;
				end else begin
					step_phase = data_byte[3] ? PH_NG : PH_PAYLOAD;
				end
				// The G flag is kept in the group count until the sizes are skipped.
				diffs_d  = 2'd0;
				groups_d = {7'd0, data_byte[3]};
			end
			PH_SIZES: begin
				skip_d = skip_dec;
				if (skip_dec == 6'd0) begin
					step_phase = (groups_q != 8'd0) ? PH_NG : PH_PAYLOAD;
				end
			end
			PH_NG: begin
				groups_d   = data_byte;
				step_phase = (data_byte != 8'd0) ? PH_GROUP : PH_PAYLOAD;
			end
			PH_GROUP: begin
				diffs_d = diffs_new;
				if (diffs_new != 2'd0) begin
					step_phase = PH_DIFFS;
				end else begin
					groups_d   = groups_dec;
					step_phase = (groups_dec == 8'd0) ? PH_PAYLOAD : PH_GROUP;
				end
			end
			PH_DIFFS: begin
				diffs_d = diffs_dec;
				if (diffs_dec == 2'd0) begin
					groups_d   = groups_dec;
					step_phase = (groups_dec == 8'd0) ? PH_PAYLOAD : PH_GROUP;
				end
			end
			PH_PAYLOAD: begin
				seen_d = 1'b1;
			end
			default: begin
				// Flags byte: start a new descriptor.
				flags_d    = data_byte[7:1];
				seen_d     = 1'b0;
				refs_d     = 2'd0;
				skip_d     = 6'd0;
				groups_d   = 8'd0;
				diffs_d    = 2'd0;
				step_phase = phase_from(SEC_PID, data_byte[7:1]);
			end
		endcase
		phase_d = step_phase;
	end

	// Result flags for this byte.
	always_comb begin
		pay = (cur_phase == PH_PAYLOAD);
		fb  = pay && !seen_q && flags_q[FL_B];
	end

	// Parse state: the last byte of a packet returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FLAGS;
			flags_q  <= '0;
			skip_q   <= '0;
			groups_q <= '0;
			diffs_q  <= '0;
			refs_q   <= '0;
			seen_q   <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q  <= PH_FLAGS;
				flags_q  <= '0;
				skip_q   <= '0;
				groups_q <= '0;
				diffs_q  <= '0;
				refs_q   <= '0;
				seen_q   <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				flags_q  <= flags_d;
				skip_q   <= skip_d;
				groups_q <= groups_d;
				diffs_q  <= diffs_d;
				refs_q   <= refs_d;
				seen_q   <= seen_d;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; loaded only together with a new request.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= data_byte;
			pay_q      <= pay;
			fb_q       <= fb;
			fe_q       <= last_byte && pay && marker_bit;
			err_q      <= last_byte && !pay;
			eop_q      <= last_byte;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign is_payload    = pay_q;
	assign frame_begin   = fb_q;
	assign frame_end     = fe_q;
	assign packet_error  = err_q;
	assign end_of_packet = eop_q;

	// A packet cannot both end cleanly and end inside its descriptor.
	a_end_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_end && packet_error))
		else $error("frame_end and packet_error set together");

	// Frame begin is only ever tagged on a payload byte.
	a_fb_pay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_begin |-> is_payload)
		else $error("frame_begin on a descriptor byte");

	// After the last byte of a packet the parser waits for a flags byte.
	a_last_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> phase_q == PH_FLAGS && !seen_q)
		else $error("parse state not cleared after end of packet");

	// A result held under back-pressure stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_byte_q))
		else $error("held result changed under back-pressure");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the VP9 RTP descriptor parser. Packets are fed one request at
// a time, and each result is checked against a cycle-free model of the
// descriptor walk that is kept inside this module.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vp9rtp_pkg::*;

	// One request on the input channel.
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       marker;
	} byte_req_t;

	// One result on the output channel, in port order.
	typedef struct packed {
		logic [7:0] data;
		logic       payload;
		logic       frame_begin;
		logic       frame_end;
		logic       error;
		logic       eop;
	} byte_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       last_byte = 1'b0;
	logic       marker_bit = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       is_payload;
	logic       frame_begin;
	logic       frame_end;
	logic       packet_error;
	logic       end_of_packet;

	vp9_rtp_descriptor_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.marker_bit   (marker_bit),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.is_payload   (is_payload),
		.frame_begin  (frame_begin),
		.frame_end    (frame_end),
		.packet_error (packet_error),
		.end_of_packet(end_of_packet)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be driven, and results the parser still owes us.
	byte_req_t    pending_requests[$];
	byte_result_t expected_results[$];
	int           error_count = 0;

	// Set at a rising edge that accepted the request currently on the bus.
	logic         in_taken = 1'b0;

	// ------------------------------------------------------------------
	// Descriptor model. It walks the same sections as the hardware: flags,
	// picture ID, layer index with TL0PICIDX, reference diffs and the
	// scalability structure, then treats every later byte as payload.
	// ------------------------------------------------------------------
	phase_t      walk_phase = PH_FLAGS;
	flags_t      walk_flags = '0;
	logic [5:0]  sizes_left = '0;
	logic [7:0]  groups_left = '0;
	logic [1:0]  diffs_left = '0;
	logic [1:0]  refs_count = '0;
	logic        payload_started = 1'b0;

	function automatic phase_t next_present_section(input section_t sec);
		phase_t ph;
		ph = PH_PAYLOAD;
		if (walk_flags[FL_V]) begin
			ph = PH_SS;
		end
		if (sec <= SEC_REF && walk_flags[FL_P] && walk_flags[FL_F]) begin
			ph = PH_REF;
		end
		if (sec <= SEC_LAYER && walk_flags[FL_L]) begin
			ph = PH_LAYER;
		end
		if (sec == SEC_PID && walk_flags[FL_I]) begin
			ph = PH_PID1;
		end
		return ph;
	endfunction

	// A picture group has been skipped entirely; move to the next one or
	// leave the descriptor when none are left.
	function automatic phase_t finish_group();
		groups_left = groups_left - 8'd1;
		return (groups_left == 8'd0) ? PH_PAYLOAD : PH_GROUP;
	endfunction

	function automatic byte_result_t parse_descriptor_byte(input byte_req_t req);
		byte_result_t res;
		logic         pay;
		logic         fb;
		pay = 1'b0;
		fb = 1'b0;
		// A start mark always restarts the walk at the flags byte.
		if (req.first) begin
			walk_phase = PH_FLAGS;
		end
		case (walk_phase)
			PH_PID1: begin
				walk_phase = req.data[7] ? PH_PID2 : next_present_section(SEC_LAYER);
			end
			PH_PID2: begin
				walk_phase = next_present_section(SEC_LAYER);
			end
			PH_LAYER: begin
				// Only non-flexible mode carries TL0PICIDX.
				walk_phase = walk_flags[FL_F] ? next_present_section(SEC_REF) : PH_TL0;
			end
			PH_TL0: begin
				walk_phase = next_present_section(SEC_REF);
			end
			PH_REF: begin
				// The chain stops at its third byte whatever the N bit says.
				refs_count = refs_count + 2'd1;
				if (!(req.data[0] && refs_count < MAX_REFS)) begin
					walk_phase = next_present_section(SEC_SS);
				end
			end
			PH_SS: begin
				if (req.data[4]) begin
					sizes_left = (6'(req.data[7:5]) + 6'd1) << 2;
					walk_phase = PH_SIZES;
				end else begin
					walk_phase = req.data[3] ? PH_NG : PH_PAYLOAD;
				end
				// The G bit is parked in the group count until the sizes pass.
				diffs_left = '0;
				groups_left = req.data[3] ? 8'd1 : 8'd0;
			end
			PH_SIZES: begin
				sizes_left = sizes_left - 6'd1;
				if (sizes_left == 6'd0) begin
					walk_phase = (groups_left != 8'd0) ? PH_NG : PH_PAYLOAD;
				end
			end
			PH_NG: begin
				groups_left = req.data;
				walk_phase = (req.data != 8'd0) ? PH_GROUP : PH_PAYLOAD;
			end
			PH_GROUP: begin
				diffs_left = req.data[3:2];
				walk_phase = (diffs_left != 2'd0) ? PH_DIFFS : finish_group();
			end
			PH_DIFFS: begin
				diffs_left = diffs_left - 2'd1;
				if (diffs_left == 2'd0) begin
					walk_phase = finish_group();
				end
			end
			PH_PAYLOAD: begin
				pay = 1'b1;
				if (!payload_started) begin
					fb = walk_flags[FL_B];
					payload_started = 1'b1;
				end
			end
			default: begin
				walk_flags = req.data[7:1];
				payload_started = 1'b0;
				refs_count = '0;
				sizes_left = '0;
				groups_left = '0;
				diffs_left = '0;
				walk_phase = next_present_section(SEC_PID);
			end
		endcase
		res.data = req.data;
		res.payload = pay;
		res.frame_begin = fb;
		res.frame_end = req.last && pay && req.marker;
		res.error = req.last && !pay;
		res.eop = req.last;
		// The end of a packet puts the walk back to its reset state.
		if (req.last) begin
			walk_phase = PH_FLAGS;
			walk_flags = '0;
			sizes_left = '0;
			groups_left = '0;
			diffs_left = '0;
			refs_count = '0;
			payload_started = 1'b0;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction.
	// ------------------------------------------------------------------
	task automatic push_req(input logic [7:0] d, input logic f, input logic l,
			input logic m);
		pending_requests.push_back('{d, f, l, m});
	endtask

	// Builds one packet with a descriptor drawn at random, then often
	// damages it: cut short, missing start or end mark, a restart in the
	// middle, or plain noise in its place.
	task automatic queue_random_packet();
		byte_req_t  pkt[$];
		logic [7:0] fl;
		logic [7:0] b;
		logic       mk;
		int         ns;
		int         ng;
		int         k;
		int         r;
		int         cut;
		int         sel;
		mk = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 9);
		if (sel == 9) begin
			for (k = $urandom_range(1, 6); k > 0; k--) begin
				pkt.push_back('{8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)});
			end
		end else begin
			fl = 8'($urandom);
			pkt.push_back('{fl, 1'b1, 1'b0, mk});
			if (fl[7]) begin
				b = 8'($urandom);
				pkt.push_back('{b, 1'b0, 1'b0, mk});
				if (b[7]) begin
					pkt.push_back('{8'($urandom), 1'b0, 1'b0, mk});
				end
			end
			if (fl[5]) begin
				pkt.push_back('{8'($urandom), 1'b0, 1'b0, mk});
				if (!fl[4]) begin
					pkt.push_back('{8'($urandom), 1'b0, 1'b0, mk});
				end
			end
			if (fl[6] && fl[4]) begin
				// Keep the N bit set most of the time so long chains show up.
				for (k = 0; k < 4; k++) begin
					b = 8'($urandom);
					b[0] = ($urandom_range(0, 2) != 0);
					pkt.push_back('{b, 1'b0, 1'b0, mk});
					if (!b[0] || k == 2) begin
						break;
					end
				end
			end
			if (fl[1]) begin
				b = 8'($urandom);
				ns = ($urandom_range(0, 7) == 0) ? 7 : $urandom_range(0, 1);
				b[7:5] = 3'(ns);
				pkt.push_back('{b, 1'b0, 1'b0, mk});
				if (b[4]) begin
					for (k = 0; k < (ns + 1) * 4; k++) begin
						pkt.push_back('{8'($urandom), 1'b0, 1'b0, mk});
					end
				end
				if (b[3]) begin
					ng = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
					pkt.push_back('{8'(ng), 1'b0, 1'b0, mk});
					for (k = 0; k < ng; k++) begin
						b = 8'($urandom);
						pkt.push_back('{b, 1'b0, 1'b0, mk});
						for (r = 0; r < int'(b[3:2]); r++) begin
							pkt.push_back('{8'($urandom), 1'b0, 1'b0, mk});
						end
					end
				end
			end
			for (k = $urandom_range(0, 5); k > 0; k--) begin
				pkt.push_back('{8'($urandom), 1'b0, 1'b0, mk});
			end
			if (sel == 0) begin
				cut = $urandom_range(1, pkt.size());
				while (pkt.size() > cut) begin
					void'(pkt.pop_back());
				end
			end
			if (sel == 1) begin
				pkt[0].first = 1'b0;
			end
			if (sel == 3 && pkt.size() > 1) begin
				pkt[$urandom_range(1, pkt.size() - 1)].first = 1'b1;
			end
			if (sel != 2) begin
				pkt[pkt.size() - 1].last = 1'b1;
			end
		end
		foreach (pkt[i]) begin
			pending_requests.push_back(pkt[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of requests with random gaps between them. The bus
	// only moves on after the previous request was taken.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : request_driver
		byte_req_t req;
		int        gap_left;
		int        burst_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			burst_left = $urandom_range(1, 40);
		end else if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req = pending_requests.pop_front();
				data_byte <= req.data;
				first_byte <= req.first;
				last_byte <= req.last;
				marker_bit <= req.marker;
				in_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: out_ready follows a pattern that is drawn again periodically:
	// always ready, alternating, random stalls, or runs of stalls.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : result_sink
		int rx_cycle;
		int rx_mode;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle = 0;
			rx_mode = 0;
		end else begin
			if (rx_cycle % 48 == 0) begin
				rx_mode = $urandom_range(0, 3);
			end
			rx_cycle++;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= rx_cycle[0];
				2: out_ready <= ($urandom_range(0, 2) != 0);
				default: out_ready <= ((rx_cycle % 16) < 9);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check the result taken at this edge first, then predict the
	// request taken at this edge. A result is registered and so always trails
	// its request, so that order is safe.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : byte_checker
		byte_result_t got;
		byte_result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{out_byte, is_payload, frame_begin, frame_end, packet_error,
					end_of_packet};
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: result with no request behind it: byte %02h pay %b",
							$realtime, got.data, got.payload);
					end
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%0t: byte exp %02h got %02h, pay exp %b got %b, begin exp %b got %b",
								$realtime, want.data, got.data, want.payload, got.payload,
								want.frame_begin, got.frame_begin);
							$display("    end exp %b got %b, error exp %b got %b, eop exp %b got %b",
								want.frame_end, got.frame_end, want.error, got.error,
								want.eop, got.eop);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(parse_descriptor_byte(
					'{data_byte, first_byte, last_byte, marker_bit}));
				in_taken <= 1'b1;
			end else begin
				in_taken <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		// Right after reset, with no start mark: a lone byte that is both the
		// flags byte and the end of the packet is a truncated descriptor.
		push_req(8'h00, 1'b0, 1'b1, 1'b1);
		// A packet with a picture ID that is dropped by a new start mark.
		push_req(8'h80, 1'b1, 1'b0, 1'b0);
		// Every flag set: 15-bit picture ID, layer index in flexible mode,
		// three chained reference diffs with the last one still asking for
		// more, then sizes for one layer and an empty group list.
		push_req(8'hFF, 1'b1, 1'b0, 1'b0);
		push_req(8'h80, 1'b0, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b0, 1'b0);
		push_req(8'h5A, 1'b0, 1'b0, 1'b0);
		push_req(8'h01, 1'b0, 1'b0, 1'b0);
		push_req(8'h03, 1'b0, 1'b0, 1'b0);
		push_req(8'hFF, 1'b0, 1'b0, 1'b0);
		push_req(8'h18, 1'b0, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b0, 1'b0);
		push_req(8'h7F, 1'b0, 1'b0, 1'b0);
		push_req(8'h80, 1'b0, 1'b0, 1'b0);
		push_req(8'hFF, 1'b0, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b0, 1'b0);
		push_req(8'h33, 1'b0, 1'b1, 1'b0);
		// Non-flexible mode: 7-bit picture ID, layer index with TL0PICIDX,
		// one picture group with three diffs, and a marked final byte.
		push_req(8'hA2, 1'b1, 1'b0, 1'b1);
		push_req(8'h7F, 1'b0, 1'b0, 1'b1);
		push_req(8'h00, 1'b0, 1'b0, 1'b1);
		push_req(8'hC3, 1'b0, 1'b0, 1'b1);
		push_req(8'h08, 1'b0, 1'b0, 1'b1);
		push_req(8'h01, 1'b0, 1'b0, 1'b1);
		push_req(8'h0C, 1'b0, 1'b0, 1'b1);
		push_req(8'h11, 1'b0, 1'b0, 1'b1);
		push_req(8'h22, 1'b0, 1'b0, 1'b1);
		push_req(8'h44, 1'b0, 1'b0, 1'b1);
		push_req(8'hA5, 1'b0, 1'b1, 1'b1);
		while (pending_requests.size() < 1077) begin
			queue_random_packet();
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last request to be taken and its result to come out,
		// then let the clock run on so that any stray result would show.
		while (pending_requests.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (5) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Guard against a hung handshake. A correct run needs well under a
	// tenth of this.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
